// File: design/table_linear_interpolator_macros.svh
// Assertion macros for the table interpolator.
// Used by design/table_linear_interpolator.sv; needs a clk and rst in scope.
`ifndef TABLE_LINEAR_INTERPOLATOR_MACROS_SVH
`define TABLE_LINEAR_INTERPOLATOR_MACROS_SVH

// checked only out of reset
`define TLI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define TLI_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/tli_pkg.sv
// Shared constants for the table interpolator: defaults, request modes,
// order and status codes, config register indexes. No dependencies.
package tli_pkg;

  localparam int TLI_TABLE_DEPTH = 1024;
  localparam int TLI_VALUE_WIDTH = 32;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;
  localparam int CLAMP_W     = 31;
  localparam int FLOOR_W     = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_X_CLAMP_MAX = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_Y_FLOOR     = 1'd1;

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  localparam logic [1:0] ORD_ASC      = 2'd0;
  localparam logic [1:0] ORD_DESC     = 2'd1;
  localparam logic [1:0] ORD_UNSORTED = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_UNSORTED = 2'd2;

endpackage

// File: design/table_linear_interpolator.sv
// Piecewise linear table interpolator: table memories, sequencer, one shared adder.
// Depends on tli_pkg and table_linear_interpolator_macros.svh.
//
// Clear and append requests are done in the idle state and never raise req_stall.
// A query holds req_stall until it finishes, far sooner for an error or a point
// outside the table: it reads the two end entries, binary searches the table one
// memory read per cycle, then a single add/subtract unit does the differences, a
// one-bit-per-cycle multiply of |dy| by |x - x(i)| and a one-bit-per-cycle
// restoring divide by |dx|, the final add and the floor compare. req_stall is high
// for the whole query; a finished result may wait in the output register while the
// next request is taken.
`include "table_linear_interpolator_macros.svh"

module table_linear_interpolator #(
  parameter int TABLE_DEPTH = tli_pkg::TLI_TABLE_DEPTH,
  parameter int VALUE_WIDTH = tli_pkg::TLI_VALUE_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [tli_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tli_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  logic [1:0]                       mode,
  input  logic signed [VALUE_WIDTH-1:0]    x_value,
  input  logic signed [VALUE_WIDTH-1:0]    y_value,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output logic signed [VALUE_WIDTH-1:0]    y_result,
  output logic [1:0]                       status,
  output logic                             overflowed
);

  localparam int W  = VALUE_WIDTH;
  localparam int UW = W + 2;
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int SW = $clog2(W + 1);
  localparam int EW = ((W > tli_pkg::CLAMP_W) ? W : tli_pkg::CLAMP_W) + 1;
  localparam int FW = (W > tli_pkg::FLOOR_W) ? W : tli_pkg::FLOOR_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK0 = 4'd1;
  localparam logic [3:0] S_CHKN = 4'd2;
  localparam logic [3:0] S_SRCH = 4'd3;
  localparam logic [3:0] S_LD0  = 4'd4;
  localparam logic [3:0] S_LD1  = 4'd5;
  localparam logic [3:0] S_DU   = 4'd6;
  localparam logic [3:0] S_DX   = 4'd7;
  localparam logic [3:0] S_DY   = 4'd8;
  localparam logic [3:0] S_DYN  = 4'd9;
  localparam logic [3:0] S_MUL  = 4'd10;
  localparam logic [3:0] S_DIV  = 4'd11;
  localparam logic [3:0] S_ADDQ = 4'd12;
  localparam logic [3:0] S_FLR  = 4'd13;
  localparam logic [3:0] S_FIN  = 4'd14;

  logic [3:0]    state;
  logic [CW-1:0] entry_count;
  logic [1:0]    table_order;
  logic          overflow_flag;
  logic signed [W-1:0] last_x;
  logic [tli_pkg::CLAMP_W-1:0] x_clamp_max;
  logic [tli_pkg::FLOOR_W-1:0] y_floor;

  logic signed [W-1:0] x_mem [TABLE_DEPTH];
  logic signed [W-1:0] y_mem [TABLE_DEPTH];
  logic signed [W-1:0] x_rd, y_rd;
  logic [AW-1:0] rd_addr, addr_q;

  logic signed [W-1:0] xq, xa, ya, xb, yb, yr;
  logic [1:0]    res_status;
  logic [AW-1:0] lo, hi;
  logic [W:0]    dx, mcand, phi, plo;
  logic          dyneg;
  logic [SW-1:0] step;

  // shared add/subtract unit
  logic [UW-1:0] alu_a, alu_b, alu_res;
  logic          alu_sub, alu_neg, alu_zero;

  logic req_take, asc, out_free;
  logic [AW-1:0] cnt_m1, lo_n, hi_n, span_n, mid_n;
  logic [AW:0]   mid_sum;
  logic          left, hit0, hitn;
  logic signed [W-1:0] x_clamped;
  logic signed [EW-1:0] x_ext, clamp_ext;
  logic signed [FW-1:0] fl_ext, vmax_ext, vmin_ext;
  logic signed [W-1:0]  fl_sat;
  logic [UW-1:0] mul_sum;
  logic [W+1:0]  rem2;

  function automatic logic [UW-1:0] sx(input logic [W-1:0] v);
    sx = {{2{v[W-1]}}, v};
  endfunction

  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign asc       = (table_order == tli_pkg::ORD_ASC);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign cnt_m1    = AW'(entry_count - CW'(1));

  assign alu_res  = alu_a + (alu_b ^ {UW{alu_sub}}) + UW'(alu_sub);
  assign alu_neg  = alu_res[UW-1];
  assign alu_zero = (alu_res == '0);

  // query x clamp
  always_comb begin
    x_ext     = EW'(x_value);
    clamp_ext = EW'({1'b0, x_clamp_max});
    x_clamped = x_value;
    if (x_clamp_max != '0 && x_ext > clamp_ext) x_clamped = clamp_ext[W-1:0];
  end

  // floor saturated to the value range
  always_comb begin
    fl_ext   = FW'($signed(y_floor));
    vmax_ext = $signed({{(FW-W+1){1'b0}}, {(W-1){1'b1}}});
    vmin_ext = ~vmax_ext;
    if (fl_ext > vmax_ext)      fl_sat = vmax_ext[W-1:0];
    else if (fl_ext < vmin_ext) fl_sat = vmin_ext[W-1:0];
    else                        fl_sat = fl_ext[W-1:0];
  end

  assign hit0 = asc ? (alu_neg || alu_zero) : !alu_neg;
  assign hitn = asc ? !alu_neg : (alu_neg || alu_zero);
  assign left = asc ? !alu_neg : (alu_neg || alu_zero);

  always_comb begin
    if (state == S_SRCH) begin
      lo_n = left ? addr_q : lo;
      hi_n = left ? hi : addr_q;
    end else begin
      lo_n = '0;
      hi_n = cnt_m1;
    end
    span_n  = hi_n - lo_n;
    mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
    mid_n   = mid_sum[AW:1];
  end

  assign mul_sum = plo[0] ? alu_res : {1'b0, phi};
  assign rem2    = {phi, plo[W]};

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    rd_addr = '0;
    case (state)
      S_IDLE: begin
        alu_a = sx(last_x);
        alu_b = sx(x_value);
      end
      S_CHK0: begin
        alu_a   = sx(xq);
        alu_b   = sx(x_rd);
        rd_addr = cnt_m1;
      end
      S_CHKN, S_SRCH: begin
        alu_a   = sx(xq);
        alu_b   = sx(x_rd);
        rd_addr = (span_n > AW'(1)) ? mid_n : lo_n;
      end
      S_LD0: rd_addr = hi;
      S_DU: begin
        alu_a = asc ? sx(xq) : sx(xa);
        alu_b = asc ? sx(xa) : sx(xq);
      end
      S_DX: begin
        alu_a = asc ? sx(xb) : sx(xa);
        alu_b = asc ? sx(xa) : sx(xb);
      end
      S_DY: begin
        alu_a = sx(yb);
        alu_b = sx(ya);
      end
      S_DYN: begin
        alu_a = sx(ya);
        alu_b = sx(yb);
      end
      S_MUL: begin
        alu_a   = {1'b0, phi};
        alu_b   = {1'b0, mcand};
        alu_sub = 1'b0;
      end
      S_DIV: begin
        alu_a = rem2;
        alu_b = {1'b0, dx};
      end
      S_ADDQ: begin
        alu_a   = sx(ya);
        alu_b   = {1'b0, plo};
        alu_sub = dyneg;
      end
      S_FLR: begin
        alu_a = sx(yr);
        alu_b = sx(fl_sat);
      end
      default: ;
    endcase
  end

  // table memories
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_take && mode == tli_pkg::MODE_APPEND &&
        entry_count != CW'(TABLE_DEPTH)) begin
      x_mem[entry_count[AW-1:0]] <= x_value;
      y_mem[entry_count[AW-1:0]] <= y_value;
    end
    x_rd   <= x_mem[rd_addr];
    y_rd   <= y_mem[rd_addr];
    addr_q <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_clamp_max <= '0;
      y_floor     <= {1'b1, {(tli_pkg::FLOOR_W-1){1'b0}}};
    end else if (cfg_write) begin
      case (cfg_index)
        tli_pkg::REG_X_CLAMP_MAX: x_clamp_max <= cfg_data[tli_pkg::CLAMP_W-1:0];
        tli_pkg::REG_Y_FLOOR:     y_floor     <= cfg_data[tli_pkg::FLOOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      entry_count   <= '0;
      table_order   <= tli_pkg::ORD_ASC;
      overflow_flag <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_take) begin
            case (mode)
              tli_pkg::MODE_CLEAR: begin
                entry_count   <= '0;
                table_order   <= tli_pkg::ORD_ASC;
                overflow_flag <= 1'b0;
              end
              tli_pkg::MODE_APPEND: begin
                if (entry_count == CW'(TABLE_DEPTH)) begin
                  overflow_flag <= 1'b1;
                end else begin
                  entry_count <= entry_count + CW'(1);
                  last_x      <= x_value;
                  if (entry_count == '0) begin
                    table_order <= tli_pkg::ORD_ASC;
                  end else if (alu_zero) begin
                    table_order <= tli_pkg::ORD_UNSORTED;
                  end else if (entry_count == CW'(1)) begin
                    table_order <= alu_neg ? tli_pkg::ORD_ASC : tli_pkg::ORD_DESC;
                  end else if (table_order != (alu_neg ? tli_pkg::ORD_ASC
                                                       : tli_pkg::ORD_DESC)) begin
                    table_order <= tli_pkg::ORD_UNSORTED;
                  end
                end
              end
              tli_pkg::MODE_QUERY: begin
                xq <= x_clamped;
                yr <= '0;
                if (entry_count == '0) begin
                  res_status <= tli_pkg::ST_EMPTY;
                  state      <= S_FIN;
                end else if (table_order == tli_pkg::ORD_UNSORTED) begin
                  res_status <= tli_pkg::ST_UNSORTED;
                  state      <= S_FIN;
                end else begin
                  res_status <= tli_pkg::ST_OK;
                  state      <= S_CHK0;
                end
              end
              default: ;
            endcase
          end
        end
        S_CHK0: begin
          if (hit0) begin
            yr    <= y_rd;
            state <= S_FLR;
          end else begin
            state <= S_CHKN;
          end
        end
        S_CHKN, S_SRCH: begin
          if (state == S_CHKN && hitn) begin
            yr    <= y_rd;
            state <= S_FLR;
          end else begin
            lo    <= lo_n;
            hi    <= hi_n;
            state <= (span_n > AW'(1)) ? S_SRCH : S_LD0;
          end
        end
        S_LD0: begin
          xa    <= x_rd;
          ya    <= y_rd;
          state <= S_LD1;
        end
        S_LD1: begin
          xb    <= x_rd;
          yb    <= y_rd;
          state <= S_DU;
        end
        S_DU: begin
          plo   <= alu_res[W:0];
          state <= S_DX;
        end
        S_DX: begin
          dx    <= alu_res[W:0];
          state <= S_DY;
        end
        S_DY: begin
          dyneg <= alu_neg;
          mcand <= alu_res[W:0];
          phi   <= '0;
          step  <= '0;
          state <= alu_neg ? S_DYN : S_MUL;
        end
        S_DYN: begin
          mcand <= alu_res[W:0];
          state <= S_MUL;
        end
        S_MUL: begin
          phi <= mul_sum[W+1:1];
          plo <= {mul_sum[0], plo[W:1]};
          if (step == SW'(W)) begin
            step  <= '0;
            state <= S_DIV;
          end else begin
            step <= step + SW'(1);
          end
        end
        S_DIV: begin
          // restoring divide: remainder in phi, quotient shifts into plo
          phi  <= alu_neg ? rem2[W:0] : alu_res[W:0];
          plo  <= {plo[W-1:0], !alu_neg};
          step <= step + SW'(1);
          if (step == SW'(W)) state <= S_ADDQ;
        end
        S_ADDQ: begin
          yr    <= alu_res[W-1:0];
          state <= S_FLR;
        end
        S_FLR: begin
          if (alu_neg) yr <= fl_sat;
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      y_result   <= yr;
      status     <= res_status;
      overflowed <= overflow_flag;
    end
  end

  `TLI_ASSERT(a_err_zero, rsp_valid && status != tli_pkg::ST_OK |-> y_result == '0, "error result not zero")
  `TLI_ASSERT_ALWAYS(a_count_range, !rst |-> entry_count <= CW'(TABLE_DEPTH), "entry count beyond depth")
  `TLI_ASSERT(a_empty_fast, req_take && mode == tli_pkg::MODE_QUERY && entry_count == '0 |=> state == S_FIN, "empty query not finished at once")
  `TLI_ASSERT(a_search_bracket, state == S_SRCH |-> lo < hi, "search bracket collapsed")

endmodule

// File: sim/tli_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the table interpolator: mirrors the table and registers from the
// observed channels, predicts each query answer and compares. Depends on tli_pkg.
module tli_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [tli_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tli_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            req_valid,
  input  logic                            req_stall,
  input  logic [1:0]                      mode,
  input  logic signed [31:0]              x_value,
  input  logic signed [31:0]              y_value,
  input  logic                            rsp_valid,
  input  logic                            rsp_stall,
  input  logic signed [31:0]              y_result,
  input  logic [1:0]                      status,
  input  logic                            overflowed,
  output int                              fail_count,
  output int                              pending
);

  typedef struct packed {
    logic signed [31:0] y;
    logic [1:0]         st;
    logic               ovf;
  } answer_t;

  logic signed [31:0] x_tab [tli_pkg::TLI_TABLE_DEPTH];
  logic signed [31:0] y_tab [tli_pkg::TLI_TABLE_DEPTH];
  int                 n_entries;
  logic [1:0]         order;
  logic               ovf_flag;
  logic [30:0]        clamp_max;
  logic signed [31:0] floor_val;
  answer_t            answers_due [$];

  function automatic longint absdiff(longint a, longint b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic answer_t answer_query(logic signed [31:0] xq);
    answer_t            r;
    longint             x, dx, u, ady, q, y0, y1;
    int                 lo, hi, mid;
    bit                 asc, left;
    r.ovf = ovf_flag;
    r.y = '0;
    if (n_entries == 0) begin
      r.st = tli_pkg::ST_EMPTY;
    end else if (order == tli_pkg::ORD_UNSORTED) begin
      r.st = tli_pkg::ST_UNSORTED;
    end else begin
      r.st = tli_pkg::ST_OK;
      x = xq;
      if (clamp_max != 0 && x > longint'(clamp_max)) x = clamp_max;
      asc = (order == tli_pkg::ORD_ASC);
      lo = 0;
      hi = n_entries - 1;
      if (asc ? (x <= x_tab[0]) : (x >= x_tab[0])) begin
        y0 = y_tab[0];
      end else if (asc ? (x >= x_tab[hi]) : (x <= x_tab[hi])) begin
        y0 = y_tab[hi];
      end else begin
        while (hi - lo > 1) begin
          mid = (lo + hi) / 2;
          left = asc ? (x_tab[mid] <= x) : (x_tab[mid] >= x);
          if (left) lo = mid;
          else hi = mid;
        end
        y0 = y_tab[lo];
        y1 = y_tab[lo+1];
        dx = absdiff(x_tab[lo+1], x_tab[lo]);
        u = absdiff(x, x_tab[lo]);
        ady = absdiff(y1, y0);
        // product stays below 2^64, so an unsigned 64-bit divide is exact
        q = longint'($unsigned(ady) * $unsigned(u) / $unsigned(dx));
        y0 = (y1 >= y0) ? y0 + q : y0 - q;
      end
      if (y0 < floor_val) y0 = floor_val;
      r.y = y0[31:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    answer_t a;
    logic [1:0] step_ord;
    if (rst) begin
      n_entries <= 0;
      order <= tli_pkg::ORD_ASC;
      ovf_flag <= 1'b0;
      clamp_max <= '0;
      floor_val <= 32'sh8000_0000;
      fail_count <= 0;
      answers_due.delete();
      pending <= 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == tli_pkg::REG_X_CLAMP_MAX) clamp_max <= cfg_data[30:0];
        else if (cfg_index == tli_pkg::REG_Y_FLOOR) floor_val <= cfg_data;
      end
      if (req_valid && !req_stall) begin
        case (mode)
          tli_pkg::MODE_CLEAR: begin
            n_entries <= 0;
            order <= tli_pkg::ORD_ASC;
            ovf_flag <= 1'b0;
          end
          tli_pkg::MODE_APPEND: begin
            if (n_entries >= tli_pkg::TLI_TABLE_DEPTH) begin
              ovf_flag <= 1'b1;
            end else begin
              if (n_entries == 0) begin
                order <= tli_pkg::ORD_ASC;
              end else if (order != tli_pkg::ORD_UNSORTED) begin
                step_ord = (x_tab[n_entries-1] < x_value) ? tli_pkg::ORD_ASC :
                           (x_tab[n_entries-1] > x_value) ? tli_pkg::ORD_DESC :
                                                            tli_pkg::ORD_UNSORTED;
                if (n_entries == 1) order <= step_ord;
                else if (step_ord != order) order <= tli_pkg::ORD_UNSORTED;
              end
              x_tab[n_entries] <= x_value;
              y_tab[n_entries] <= y_value;
              n_entries <= n_entries + 1;
            end
          end
          tli_pkg::MODE_QUERY: answers_due.push_back(answer_query(x_value));
          default: ;
        endcase
      end
      if (rsp_valid && !rsp_stall) begin
        if (answers_due.size() == 0) begin
          $error("response with no query outstanding");
          fail_count <= fail_count + 1;
        end else begin
          a = answers_due.pop_front();
          if (a.y !== y_result || a.st !== status || a.ovf !== overflowed)
            fail_count <= fail_count + 1;
          if (a.y !== y_result)
            $error("y_result: expected %0d, got %0d", a.y, y_result);
          if (a.st !== status)
            $error("status: expected %0d, got %0d", a.st, status);
          if (a.ovf !== overflowed)
            $error("overflowed: expected %0d, got %0d", a.ovf, overflowed);
        end
      end
      pending <= answers_due.size();
    end
  end

endmodule

// File: sim/table_linear_interpolator_tb.sv
`timescale 1ns / 100ps
// Top of the table interpolator bench: clock, reset, request and register stimulus,
// receiver stalls, verdict. Depends on tli_pkg, tli_checker and the interpolator.
module table_linear_interpolator_tb;

  localparam int CYCLE_LIMIT = 600000;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_write = 1'b0;
  logic [tli_pkg::CFG_INDEX_W-1:0] cfg_index = tli_pkg::REG_X_CLAMP_MAX;
  logic [tli_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                            req_valid = 1'b0;
  logic                            req_stall;
  logic [1:0]                      mode = tli_pkg::MODE_CLEAR;
  logic signed [31:0]              x_value = '0;
  logic signed [31:0]              y_value = '0;
  logic                            rsp_valid;
  logic                            rsp_stall = 1'b0;
  logic signed [31:0]              y_result;
  logic [1:0]                      status;
  logic                            overflowed;
  int                     fail_count, pending, cycles = 0, hold_left = 0, sent = 0;
  bit                     quiet = 0, hold_go = 0;

  always #5 clk = ~clk;

  table_linear_interpolator dut (.*);

  tli_checker scoreboard (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_go) hold_left <= 400;
    else if (hold_left != 0) hold_left <= hold_left - 1;
    rsp_stall <= hold_go || hold_left > 1 || (!quiet && $urandom_range(99) < 21);
  end

  task automatic send(logic [1:0] m, logic signed [31:0] x, logic signed [31:0] y);
    if (!quiet && $urandom_range(99) < 21) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    mode <= m;
    x_value <= x;
    y_value <= y;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent++;
  endtask

  task automatic write_reg(logic [tli_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] data);
    req_valid <= 1'b0;
    cfg_index <= idx;
    cfg_data <= data;
    cfg_write <= 1'b1;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // waits out queries still in flight; clears and appends leave nothing behind
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 || req_stall) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic load_sorted(int n, bit desc, output int xs[$]);
    int v;
    xs.delete();
    repeat (n) begin
      v = $urandom;
      if ($urandom_range(3) == 0) v = $urandom_range(2000) - 1000;
      xs.push_back(v);
    end
    xs.sort();
    for (int i = xs.size() - 1; i > 0; i--) if (xs[i] == xs[i-1]) xs.delete(i);
    if (desc) xs.reverse();
    foreach (xs[i]) send(tli_pkg::MODE_APPEND, xs[i], $urandom);
  endtask

  initial begin
    int xs[$];
    int lo_x, hi_x, phase;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, extremes, both orders, equal x, unused mode
    send(tli_pkg::MODE_QUERY, 0, 0);
    send(tli_pkg::MODE_APPEND, 32'sh8000_0000, 32'sh7fff_ffff);
    send(tli_pkg::MODE_QUERY, 5, 0);
    send(tli_pkg::MODE_APPEND, 32'sh7fff_ffff, 32'sh8000_0000);
    send(tli_pkg::MODE_QUERY, 32'sh8000_0000, 0);
    send(tli_pkg::MODE_QUERY, 32'sh7fff_ffff, 0);
    send(tli_pkg::MODE_QUERY, 0, 0);
    send(tli_pkg::MODE_QUERY, 32'sh4000_0000, 0);
    send(tli_pkg::MODE_NONE, 32'sh1234_5678, 32'sh0);
    send(tli_pkg::MODE_CLEAR, 0, 0);
    send(tli_pkg::MODE_APPEND, 32'sh0003_0000, 32'sh0001_0000);
    send(tli_pkg::MODE_APPEND, 32'sh0001_0000, 32'sh0005_8000);
    send(tli_pkg::MODE_APPEND, -32'sh0002_0000, -32'sh0003_0000);
    send(tli_pkg::MODE_QUERY, 32'sh0002_0000, 0);
    send(tli_pkg::MODE_QUERY, 32'sh0000_0001, 0);
    send(tli_pkg::MODE_QUERY, 32'sh0001_0000, 0);
    send(tli_pkg::MODE_QUERY, -32'sh0009_0000, 0);
    send(tli_pkg::MODE_APPEND, -32'sh0002_0000, 32'sh0);
    send(tli_pkg::MODE_QUERY, 0, 0);
    send(tli_pkg::MODE_CLEAR, 0, 0);
    send(tli_pkg::MODE_APPEND, 1, 1);
    send(tli_pkg::MODE_APPEND, 1, 2);
    send(tli_pkg::MODE_QUERY, 1, 0);
    // fill the table past its depth to raise the sticky overflow
    send(tli_pkg::MODE_CLEAR, 0, 0);
    for (int i = 0; i <= tli_pkg::TLI_TABLE_DEPTH; i++)
      send(tli_pkg::MODE_APPEND, i * 4096 - 32'sh0200_0000, $urandom);
    send(tli_pkg::MODE_QUERY, $urandom_range(4000000) - 32'sh0200_0000, 0);
    send(tli_pkg::MODE_QUERY, 32'sh7fff_ffff, 0);
    send(tli_pkg::MODE_CLEAR, 0, 0);
    send(tli_pkg::MODE_QUERY, 0, 0);
    drain();

    sent = 0;
    phase = 0;
    while (sent < 400) begin
      if (phase % 3 == 0) begin
        drain();
        case ((phase / 3) % 5)
          0: begin
            write_reg(tli_pkg::REG_X_CLAMP_MAX, 32'h7fff_ffff);
            write_reg(tli_pkg::REG_Y_FLOOR, 32'h7fff_ffff);
          end
          1: begin
            write_reg(tli_pkg::REG_X_CLAMP_MAX, 1);
            write_reg(tli_pkg::REG_Y_FLOOR, 0);
          end
          2: begin
            write_reg(tli_pkg::REG_X_CLAMP_MAX, $urandom);
            write_reg(tli_pkg::REG_Y_FLOOR, $urandom);
          end
          3: begin
            write_reg(tli_pkg::REG_X_CLAMP_MAX, 0);
            write_reg(tli_pkg::REG_Y_FLOOR, 32'h8000_0000);
          end
          default: begin
            write_reg(tli_pkg::REG_X_CLAMP_MAX, $urandom_range(2000));
            write_reg(tli_pkg::REG_Y_FLOOR, $urandom);
          end
        endcase
      end
      quiet = (phase >= 6 && phase < 10);
      send(tli_pkg::MODE_CLEAR, 0, 0);
      if ($urandom_range(9) == 0) begin
        // noise: unordered appends and stray modes
        repeat ($urandom_range(1, 6)) send($urandom_range(3), $urandom, $urandom);
      end else begin
        load_sorted($urandom_range(1, 12), $urandom_range(1), xs);
        if (xs.size() > 1 && $urandom_range(5) == 0)
          send(tli_pkg::MODE_APPEND, xs[0], $urandom);
      end
      if (phase == 4) begin
        req_valid <= 1'b0;
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      repeat ($urandom_range(4, 10)) begin
        if (xs.size() == 0 || $urandom_range(4) == 0) begin
          send(tli_pkg::MODE_QUERY, $urandom, $urandom);
        end else if ($urandom_range(3) == 0) begin
          send(tli_pkg::MODE_QUERY, xs[$urandom_range(xs.size() - 1)], $urandom);
        end else begin
          lo_x = xs[0];
          hi_x = xs[xs.size() - 1];
          if (lo_x > hi_x) begin lo_x = hi_x; hi_x = xs[0]; end
          send(tli_pkg::MODE_QUERY, lo_x + int'($urandom_range(32'(hi_x - lo_x))), $urandom);
        end
      end
      phase++;
    end
    quiet = 0;
    drain();
    if (fail_count == 0 && pending == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/tli_pkg.sv
design/table_linear_interpolator.sv
sim/tli_checker.sv
sim/table_linear_interpolator_tb.sv
